// ----- design/char_lcd_write_sequencer_top_defines.svh -----
// assertion macros for the char lcd write sequencer checker
// used by clws_checker.sv, no other dependencies
`ifndef CHAR_LCD_WRITE_SEQUENCER_TOP_DEFINES_SVH
`define CHAR_LCD_WRITE_SEQUENCER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CLWS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clws assertion failed");

// antecedent implies consequent in the next cycle
`define CLWS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clws assertion failed");

// antecedent implies consequent at a later cycle
`define CLWS_ASSERT_D2(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("clws assertion failed");

`endif

// ----- design/clws_pkg.sv -----
// shared types and constants of the char lcd write sequencer
// no dependencies
package clws_pkg;

    // request codes
    localparam logic [1:0] ACT_INIT  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BIT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_LINES = 4'd1;

    // lcd commands
    localparam logic [7:0] CMD_FUNC_4BIT = 8'h20;
    localparam logic [7:0] CMD_FUNC_BASE = 8'h20;
    localparam logic [7:0] CMD_FUNC_DL8  = 8'h10;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;

    // waits in microseconds
    localparam logic [14:0] WAIT_POWER_UP = 15'd30000;
    localparam logic [14:0] WAIT_LEAD     = 15'd2000;
    localparam logic [14:0] WAIT_STROBE   = 15'd1;
    localparam logic [14:0] WAIT_NONE     = 15'd0;
    localparam logic [14:0] WAIT_HOLD     = 15'd39;
    localparam logic [14:0] WAIT_CLEAR    = 15'd1530;

    // sequencer position handed to the decoder
    typedef struct packed {
        logic       active;
        logic       pre;
        logic [2:0] byte_idx;
        logic [2:0] pos;
        logic [1:0] action;
        logic [7:0] char_code;
    } step_t;

    // one pin state
    typedef struct packed {
        logic [7:0]  data_bus;
        logic        reg_select;
        logic        enable;
        logic [14:0] wait_us;
    } pin_t;

    // decoder status back to the sequencer
    typedef struct packed {
        logic last;
        logic byte_done;
    } step_ctl_t;

endpackage

// ----- design/clws_decode.sv -----
// maps a sequencer position to one lcd pin state
// depends on clws_pkg
module clws_decode
    import clws_pkg::*;
(
    input  step_t     step,
    input  logic      four_bit_mode,
    input  logic      two_lines,
    output pin_t      pin,
    output step_ctl_t ctl
);

    logic [7:0] func_set;
    logic [2:0] tbl_idx;
    logic [7:0] init_byte;
    logic [7:0] cur_byte;
    logic       has_hold;
    logic [2:0] last_byte;
    logic [2:0] last_pos;
    logic       is_hold;
    logic       low_half;
    logic [1:0] sub;
    logic [7:0] bus;

    always_comb
    begin
        func_set = CMD_FUNC_BASE | (four_bit_mode ? 8'h00 : CMD_FUNC_DL8)
                 | {4'b0, two_lines, 3'b0};
        // 8-bit init skips the leading nibble-mode command
        tbl_idx = step.byte_idx + {2'b0, !four_bit_mode};
        case (tbl_idx)
            3'd0:    init_byte = CMD_FUNC_4BIT;
            3'd1:    init_byte = func_set;
            3'd2:    init_byte = CMD_DISP_ON;
            3'd3:    init_byte = CMD_CLEAR;
            3'd4:    init_byte = CMD_ENTRY;
            default: init_byte = 8'h00;
        endcase

        case (step.action)
            ACT_INIT:  cur_byte = init_byte;
            ACT_WRITE: cur_byte = step.char_code;
            ACT_CLEAR: cur_byte = CMD_CLEAR;
            default:   cur_byte = 8'h00;
        endcase

        has_hold  = (step.action != ACT_WRITE);
        last_byte = (step.action == ACT_INIT) ? (four_bit_mode ? 3'd4 : 3'd3) : 3'd0;
        if (four_bit_mode)
        begin
            last_pos = has_hold ? 3'd6 : 3'd5;
            is_hold  = (step.pos == 3'd6);
            low_half = (step.pos >= 3'd3);
        end
        else
        begin
            last_pos = has_hold ? 3'd3 : 3'd2;
            is_hold  = (step.pos == 3'd3);
            low_half = 1'b0;
        end
        sub = low_half ? 2'(step.pos - 3'd3) : 2'(step.pos);

        if (!four_bit_mode)
            bus = cur_byte;
        else if (low_half)
            bus = {cur_byte[3:0], 4'b0};
        else
            bus = {cur_byte[7:4], 4'b0};

        if (step.pre)
        begin
            pin.data_bus   = 8'h00;
            pin.reg_select = 1'b0;
            pin.enable     = 1'b0;
            pin.wait_us    = WAIT_POWER_UP;
        end
        else if (is_hold)
        begin
            pin.data_bus   = bus;
            pin.reg_select = 1'b0;
            pin.enable     = 1'b0;
            pin.wait_us    = (cur_byte == CMD_CLEAR) ? WAIT_CLEAR : WAIT_HOLD;
        end
        else
        begin
            pin.data_bus   = bus;
            pin.reg_select = (step.action == ACT_WRITE);
            pin.enable     = (sub == 2'd1);
            if (sub == 2'd0)
                pin.wait_us = low_half ? WAIT_NONE : WAIT_LEAD;
            else
                pin.wait_us = WAIT_STROBE;
        end

        ctl.byte_done = (step.pos == last_pos);
        ctl.last      = !step.pre && (step.byte_idx == last_byte) && ctl.byte_done;
    end

endmodule

// ----- design/clws_seq.sv -----
// request register and step counters of the char lcd write sequencer
// depends on clws_pkg
module clws_seq
    import clws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] action,
    input  logic [7:0] char_code,
    input  step_ctl_t  ctl,
    output logic       busy,
    output step_t      step
);

    logic       active_reg, active_next;
    logic       pre_reg, pre_next;
    logic [2:0] byte_reg, byte_next;
    logic [2:0] pos_reg, pos_next;
    logic [1:0] action_reg, action_next;
    logic [7:0] char_reg, char_next;
    logic       go;

    always_comb
    begin
        // free again in the cycle the final state is formed
        busy = active_reg && !ctl.last;
        go   = start && !busy && (action inside {ACT_INIT, ACT_WRITE, ACT_CLEAR});

        active_next = active_reg;
        pre_next    = pre_reg;
        byte_next   = byte_reg;
        pos_next    = pos_reg;
        action_next = action_reg;
        char_next   = char_reg;

        if (go)
        begin
            active_next = 1'b1;
            pre_next    = (action == ACT_INIT);
            byte_next   = 3'd0;
            pos_next    = 3'd0;
            action_next = action;
            char_next   = char_code;
        end
        else if (active_reg)
        begin
            if (ctl.last)
                active_next = 1'b0;
            else if (pre_reg)
                pre_next = 1'b0;
            else if (ctl.byte_done)
            begin
                pos_next  = 3'd0;
                byte_next = byte_reg + 3'd1;
            end
            else
                pos_next = pos_reg + 3'd1;
        end

        step.active    = active_reg;
        step.pre       = pre_reg;
        step.byte_idx  = byte_reg;
        step.pos       = pos_reg;
        step.action    = action_reg;
        step.char_code = char_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pre_reg    <= 1'b0;
            byte_reg   <= 3'd0;
            pos_reg    <= 3'd0;
        end
        else
        begin
            active_reg <= active_next;
            pre_reg    <= pre_next;
            byte_reg   <= byte_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        char_reg   <= char_next;
    end

endmodule

// ----- design/char_lcd_write_sequencer_top.sv -----
// char lcd write sequencer: one request in, a run of bus pin states out
// first pin state strobes on out_valid after start passes the step counter and result register
// throughput: one pin state per cycle; init gives 36 states in 4-bit mode, 17 in 8-bit,
//   write gives 6 or 3, clear 7 or 4; action 3 gives none and frees at once
// the step counter in clws_seq sets the pace; the next start is taken in the last state's
//   cycle, so runs follow with no gap; reset clears the run and sets four_bit_mode 0, two_lines 1
module char_lcd_write_sequencer_top
    import clws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request transfer
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           action,
    input  logic [7:0]           char_code,
    // configuration write transfer
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    // pin state results, one cycle each
    output logic                 out_valid,
    output logic [7:0]           data_bus,
    output logic                 reg_select,
    output logic                 enable,
    output logic [14:0]          wait_us,
    output logic                 last
);

    // configuration registers
    logic four_bit_reg, four_bit_next;
    logic two_lines_reg, two_lines_next;

    // result register
    logic  valid_reg, valid_next;
    logic  last_reg, last_next;
    pin_t  pin_reg;

    step_t     step;
    pin_t      pin;
    step_ctl_t ctl;

    // config writes are always taken; indexes past the list are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        four_bit_next  = four_bit_reg;
        two_lines_next = two_lines_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FOUR_BIT:  four_bit_next  = cfg_data;
                CFG_TWO_LINES: two_lines_next = cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_bit_reg  <= 1'b0;
            two_lines_reg <= 1'b1;
        end
        else
        begin
            four_bit_reg  <= four_bit_next;
            two_lines_reg <= two_lines_next;
        end
    end

    // request register and step counters
    clws_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (action),
        .char_code (char_code),
        .ctl       (ctl),
        .busy      (busy),
        .step      (step)
    );

    // pin state for the current step
    clws_decode u_decode (
        .step          (step),
        .four_bit_mode (four_bit_reg),
        .two_lines     (two_lines_reg),
        .pin           (pin),
        .ctl           (ctl)
    );

    // every active step leaves one result
    always_comb
    begin
        valid_next = step.active;
        last_next  = step.active && ctl.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    // pin payload needs no reset, qualified by out_valid
    always_ff @(posedge clk)
    begin
        pin_reg <= pin;
    end

    assign out_valid  = valid_reg;
    assign last       = last_reg;
    assign data_bus   = pin_reg.data_bus;
    assign reg_select = pin_reg.reg_select;
    assign enable     = pin_reg.enable;
    assign wait_us    = pin_reg.wait_us;

endmodule

// ----- design/clws_checker.sv -----
// port-level assertions for char_lcd_write_sequencer_top, attached by bind
// depends on clws_pkg and char_lcd_write_sequencer_top_defines.svh
`include "char_lcd_write_sequencer_top_defines.svh"

module clws_checker
    import clws_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  action,
    input logic        out_valid,
    input logic        enable,
    input logic [14:0] wait_us,
    input logic        last
);

    // request code that leads to pin states
    logic known_action;

    assign known_action = (action == ACT_INIT) || (action == ACT_WRITE) || (action == ACT_CLEAR);

    // a run still in flight keeps strobing results
    `CLWS_ASSERT_NEXT(a_busy_streams, busy, out_valid)

    // an accepted request shows its first state once past the step counter and result register
    `CLWS_ASSERT_D2(a_start_latency, start && !busy && known_action, out_valid)

    // e high is always followed by e low
    `CLWS_ASSERT_NEXT(a_e_falls, out_valid && enable, out_valid && !enable)

    // e high carries a one microsecond wait and is never the final state
    `CLWS_ASSERT_NOW(a_e_timing, out_valid && enable, wait_us == 15'd1 && !last)

    // last only marks a strobed result
    `CLWS_ASSERT_NOW(a_last_valid, last, out_valid)

endmodule

bind char_lcd_write_sequencer_top clws_checker u_clws_checker (.*);
